>>> rtl/core/assert_macros.svh
// Assertion macros shared by the demosaic RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> rtl/core/bbd_pkg.sv
// Types, constants and helper functions of the Bayer bilinear demosaic.
package bbd_pkg;

   localparam int PIX_W      = 8;
   localparam int CFG_DATA_W = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int SUM_W      = 11;
   localparam int CNT_W      = 3;

   localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
   localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   localparam int RECIP3       = 683;
   localparam int RECIP3_SHIFT = 11;
   localparam int PROD_W       = SUM_W + 10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      COLOUR_RED   = 2'd0,
      COLOUR_GREEN = 2'd1,
      COLOUR_BLUE  = 2'd2
   } colour_type;

   typedef struct packed {
      logic row_odd;
      logic col_odd;
      logic top_ok;
      logic bottom_ok;
      logic left_ok;
      logic right_ok;
      logic last;
   } pos_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             frame_end;
   } pixel_out_type;

   function automatic colour_type colour_at(input logic row_odd, input logic col_odd);
      colour_type c;
      if (row_odd && !col_odd) begin
         c = COLOUR_RED;
      end else if (!row_odd && col_odd) begin
         c = COLOUR_BLUE;
      end else begin
         c = COLOUR_GREEN;
      end
      return c;
   endfunction

   function automatic logic [PIX_W-1:0] mean_floor(input logic [SUM_W-1:0] sum,
                                                   input logic [CNT_W-1:0] cnt);
      logic [PROD_W-1:0] prod;
      logic [PIX_W-1:0]  q;
      prod = PROD_W'(sum) * PROD_W'(RECIP3);
      case (cnt)
         3'd1:    q = sum[PIX_W-1:0];
         3'd2:    q = sum[PIX_W:1];
         3'd3:    q = prod[RECIP3_SHIFT +: PIX_W];
         3'd4:    q = sum[PIX_W+1:2];
         default: q = '0;
      endcase
      return q;
   endfunction

endpackage

>>> rtl/core/bayer_bilinear_demosaic.sv
// Bayer bilinear demosaic, GBRG mosaic, 3x3 window. Takes one Bayer sample per
// clock in raster order, stalled while in-flight results fill the output queue
// or a size write is presented, and gives one RGB pixel per sample, one row plus
// one pixel behind the input; after the last sample of a frame, flush beats
// drain the last row plus one pixel. Each sample reads and writes back its
// column of one line memory holding the two previous rows (read in the accept
// cycle, written the cycle after, with the pending write forwarded when a new
// frame starts on the column just written). A result passes stage A and stage
// B into a four-entry output queue, which lets input continue while results
// wait. Writing either size register restarts the frame.
module bayer_bilinear_demosaic
   import bbd_pkg::*;
#(
   parameter int unsigned MAX_WIDTH  = 4096,
   parameter int unsigned MAX_HEIGHT = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   input  logic [PIX_W-1:0]      req_raw_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIX_W-1:0]      rsp_red,
   output logic [PIX_W-1:0]      rsp_green,
   output logic [PIX_W-1:0]      rsp_blue,
   output logic                  rsp_frame_end
);

`include "assert_macros.svh"

   localparam int CLW = $clog2(MAX_WIDTH);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 2);

   logic [CFG_DATA_W-1:0] image_width_ff, image_width_in;
   logic [CFG_DATA_W-1:0] image_height_ff, image_height_in;
   logic [CLW-1:0]        in_col_ff, in_col_in;
   logic [HW-1:0]         in_row_ff, in_row_in;
   logic [CLW-1:0]        out_col_ff, out_col_in;
   logic [HW-1:0]         out_row_ff, out_row_in;

   logic [WW-1:0] w_eff, w_m1;
   logic [HW-1:0] h_eff, h_m1, h_p1;

   logic          csr_write, req_accept, draining, proc, emit, last, in_wrap, out_wrap;
   pos_type       pos_now;

   logic                  a_valid_ff, a_emit_ff;
   logic [PIX_W-1:0]      a_sample_ff;
   logic [CLW-1:0]        a_col_ff;
   pos_type               a_pos_ff;
   logic [2*PIX_W-1:0]    line_rd_ff;
   logic [2*PIX_W-1:0]    line_mem [0:MAX_WIDTH-1];
   logic                  line_fwd;

   logic [PIX_W-1:0]      win_ff [3][3];

   logic                  b_valid_ff;
   pos_type               b_pos_ff;
   pixel_out_type         b_result;

   pixel_out_type         fifo_mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] fifo_head_ff, fifo_tail_ff;
   logic [FIFO_CNT_W-1:0] fifo_count_ff;
   logic                  fifo_pop;
   logic [FIFO_CNT_W:0]   outstanding;

   always_comb begin
      if (image_width_ff < CFG_DATA_W'(2)) begin
         w_eff = WW'(2);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(image_width_ff);
      end
      if (image_height_ff < CFG_DATA_W'(2)) begin
         h_eff = HW'(2);
      end else if (32'(image_height_ff) > MAX_HEIGHT) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(image_height_ff);
      end
   end

   assign w_m1 = w_eff - 1'b1;
   assign h_m1 = h_eff - 1'b1;
   assign h_p1 = h_eff + 1'b1;

   assign outstanding = (FIFO_CNT_W+1)'(fifo_count_ff)
                      + (FIFO_CNT_W+1)'(a_valid_ff & a_emit_ff)
                      + (FIFO_CNT_W+1)'(b_valid_ff);

   assign csr_ready  = 1'b1;
   assign req_ready  = (outstanding < (FIFO_CNT_W+1)'(FIFO_DEPTH)) & ~csr_valid;
   assign csr_write  = csr_valid & csr_ready;
   assign req_accept = req_valid & req_ready;
   assign draining   = in_row_ff >= h_eff;
   assign proc       = req_accept & (~req_cmd | draining);
   assign emit       = (in_row_ff >= HW'(2)) || ((in_row_ff == HW'(1)) && (in_col_ff != '0));
   assign in_wrap    = WW'(in_col_ff) == w_m1;
   assign out_wrap   = WW'(out_col_ff) == w_m1;
   assign last       = (out_row_ff == h_m1) && out_wrap;
   assign line_fwd   = a_valid_ff && (a_col_ff == in_col_ff);

   assign pos_now.row_odd   = out_row_ff[0];
   assign pos_now.col_odd   = out_col_ff[0];
   assign pos_now.top_ok    = out_row_ff != '0;
   assign pos_now.bottom_ok = out_row_ff != h_m1;
   assign pos_now.left_ok   = out_col_ff != '0;
   assign pos_now.right_ok  = !out_wrap;
   assign pos_now.last      = last;

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      in_col_in       = in_col_ff;
      in_row_in       = in_row_ff;
      out_col_in      = out_col_ff;
      out_row_in      = out_row_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH: begin
               image_width_in = csr_wdata;
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end
            CSR_IMAGE_HEIGHT: begin
               image_height_in = csr_wdata;
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end
            default: begin
            end
         endcase
      end else if (proc) begin
         if (emit && last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else begin
            if (in_wrap) begin
               in_col_in = '0;
               if (in_row_ff != h_p1) begin
                  in_row_in = in_row_ff + 1'b1;
               end
            end else begin
               in_col_in = in_col_ff + 1'b1;
            end
            if (emit) begin
               if (out_wrap) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + 1'b1;
               end else begin
                  out_col_in = out_col_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RST;
         image_height_ff <= IMAGE_HEIGHT_RST;
         in_col_ff       <= '0;
         in_row_ff       <= '0;
         out_col_ff      <= '0;
         out_row_ff      <= '0;
         a_valid_ff      <= 1'b0;
         a_emit_ff       <= 1'b0;
         b_valid_ff      <= 1'b0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         in_col_ff       <= in_col_in;
         in_row_ff       <= in_row_in;
         out_col_ff      <= out_col_in;
         out_row_ff      <= out_row_in;
         a_valid_ff      <= proc;
         a_emit_ff       <= emit;
         b_valid_ff      <= a_valid_ff & a_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (proc) begin
         a_sample_ff <= draining ? '0 : req_raw_sample;
         a_col_ff    <= in_col_ff;
         a_pos_ff    <= pos_now;
      end
      if (a_valid_ff) begin
         b_pos_ff <= a_pos_ff;
      end
   end

   // line memory entry: older row in the high byte, newer row in the low byte
   always_ff @(posedge clock) begin
      if (a_valid_ff) begin
         line_mem[a_col_ff] <= {line_rd_ff[PIX_W-1:0], a_sample_ff};
      end
      if (proc) begin
         line_rd_ff <= line_fwd ? {line_rd_ff[PIX_W-1:0], a_sample_ff} : line_mem[in_col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               win_ff[r][k] <= '0;
            end
         end
      end else if (a_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= line_rd_ff[2*PIX_W-1:PIX_W];
         win_ff[1][2] <= line_rd_ff[PIX_W-1:0];
         win_ff[2][2] <= a_sample_ff;
      end
   end

   always_comb begin
      logic [SUM_W-1:0] sum_r, sum_g, sum_b;
      logic [CNT_W-1:0] cnt_r, cnt_g, cnt_b;
      logic             row_ok, col_ok;
      colour_type       c;
      sum_r = '0;
      sum_g = '0;
      sum_b = '0;
      cnt_r = '0;
      cnt_g = '0;
      cnt_b = '0;
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            row_ok = (r == 0) ? b_pos_ff.top_ok  : ((r == 2) ? b_pos_ff.bottom_ok : 1'b1);
            col_ok = (k == 0) ? b_pos_ff.left_ok : ((k == 2) ? b_pos_ff.right_ok  : 1'b1);
            c = colour_at(b_pos_ff.row_odd ^ (r != 1), b_pos_ff.col_odd ^ (k != 1));
            if (row_ok && col_ok) begin
               case (c)
                  COLOUR_RED: begin
                     sum_r = sum_r + SUM_W'(win_ff[r][k]);
                     cnt_r = cnt_r + 1'b1;
                  end
                  COLOUR_BLUE: begin
                     sum_b = sum_b + SUM_W'(win_ff[r][k]);
                     cnt_b = cnt_b + 1'b1;
                  end
                  default: begin
                     sum_g = sum_g + SUM_W'(win_ff[r][k]);
                     cnt_g = cnt_g + 1'b1;
                  end
               endcase
            end
         end
      end
      b_result.red       = mean_floor(sum_r, cnt_r);
      b_result.green     = mean_floor(sum_g, cnt_g);
      b_result.blue      = mean_floor(sum_b, cnt_b);
      b_result.frame_end = b_pos_ff.last;
      case (colour_at(b_pos_ff.row_odd, b_pos_ff.col_odd))
         COLOUR_RED:  b_result.red   = win_ff[1][1];
         COLOUR_BLUE: b_result.blue  = win_ff[1][1];
         default:     b_result.green = win_ff[1][1];
      endcase
   end

   assign fifo_pop      = rsp_valid & rsp_ready;
   assign rsp_valid     = fifo_count_ff != '0;
   assign rsp_red       = fifo_mem_ff[fifo_head_ff].red;
   assign rsp_green     = fifo_mem_ff[fifo_head_ff].green;
   assign rsp_blue      = fifo_mem_ff[fifo_head_ff].blue;
   assign rsp_frame_end = fifo_mem_ff[fifo_head_ff].frame_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_head_ff  <= '0;
         fifo_tail_ff  <= '0;
         fifo_count_ff <= '0;
      end else begin
         if (b_valid_ff) begin
            fifo_tail_ff <= fifo_tail_ff + 1'b1;
         end
         if (fifo_pop) begin
            fifo_head_ff <= fifo_head_ff + 1'b1;
         end
         if (b_valid_ff && !fifo_pop) begin
            fifo_count_ff <= fifo_count_ff + 1'b1;
         end else if (!b_valid_ff && fifo_pop) begin
            fifo_count_ff <= fifo_count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_valid_ff) begin
         fifo_mem_ff[fifo_tail_ff] <= b_result;
      end
   end

   `ASSERT_ALWAYS(credit_bound, clock, reset, outstanding <= (FIFO_CNT_W+1)'(FIFO_DEPTH), "results in flight exceed queue space")
   `ASSERT_IMPLIES(no_push_when_full, clock, reset, b_valid_ff && !fifo_pop, fifo_count_ff < FIFO_CNT_W'(FIFO_DEPTH), "push into full output queue")
   `ASSERT_IMPLIES(line_fwd_at_restart, clock, reset, proc && line_fwd, in_col_ff == '0, "line memory column reused away from a frame restart")
   `ASSERT_IMPLIES(result_from_stage_a, clock, reset, b_valid_ff, $past(a_valid_ff && a_emit_ff), "result without a producing beat")

endmodule
